// ===== hdl/kss_pkg.sv =====
// Shared constants, codes and types of the k-stack shared slot store.
`timescale 1ns / 1ps
package kss_pkg;

    localparam int N_SLOTS_DEF  = 64;
    localparam int K_STACKS_DEF = 8;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TOP,
        S_MOD
    } t_state;

endpackage

// ===== hdl/kss_if.sv =====
// Request and response channel interfaces of the k-stack shared slot store.
`timescale 1ns / 1ps
interface kss_req_if;
    import kss_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [INDEX_W-1:0] stack_index;
    logic signed [VALUE_W-1:0] push_value;

    modport source (output valid, operation, stack_index, push_value, input ready);
    modport sink   (input valid, operation, stack_index, push_value, output ready);
endinterface

interface kss_rsp_if;
    import kss_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] pop_value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, pop_value, status, input ready);
    modport sink   (input valid, pop_value, status, output ready);
endinterface

// ===== hdl/kss_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module kss_ram #(
    parameter int WIDTH = kss_pkg::VALUE_W,
    parameter int DEPTH = kss_pkg::N_SLOTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Read data holds between reads.
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/k_stacks_shared_store_core.sv =====
// Top level of the k-stack shared slot store: control sequencer and both stores.
`timescale 1ns / 1ps
// K_STACKS LIFO stacks share one store of N_SLOTS slots. Each request is a push
// (operation 0) or a pop (operation 1) on the stack chosen by stack_index; the
// indexes 0 to K_STACKS-1 select a stack directly, the index K_STACKS selects the
// last stack, and any larger index is rejected with status 1. Every request gives
// exactly one response: status 0 on success, 2 when a push finds no free slot,
// 3 when a pop finds its stack empty. A failed request leaves the stacks as they
// were, and pop_value is -1 for every push and every failed pop. From acceptance
// to a loaded response register, the stack top pointer is read from its RAM,
// then the slot value and link are read from the slot RAM at the address that
// pointer or the free-list head gives, and the write-back happens at the edge
// that loads the response. These two dependent synchronous reads set the rate;
// a new request is accepted no earlier than the cycle after the previous one
// commits, and a held response only stalls the block once a second one is ready
// to commit. The slot links need no clearing pass after reset: a high-water mark
// tracks the slots that were ever handed out, and a slot at or above it links to
// the next slot number.
module k_stacks_shared_store_core #(
    parameter int N_SLOTS  = kss_pkg::N_SLOTS_DEF,
    parameter int K_STACKS = kss_pkg::K_STACKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kss_req_if.sink   i_req,
    kss_rsp_if.source o_rsp
);
    import kss_pkg::*;

    // Link width holds every slot number plus the null code N_SLOTS.
    localparam int LW = $clog2(N_SLOTS + 1);
    localparam int AW = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;
    localparam int KW = (K_STACKS > 1) ? $clog2(K_STACKS) : 1;
    localparam int SW = VALUE_W + LW;
    localparam logic [LW-1:0] NULL_LINK = LW'(N_SLOTS);

    // Control and request registers.
    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [KW-1:0]        r_sel, n_sel;
    logic                 r_bad, n_bad;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [LW-1:0]        r_slot, n_slot;
    logic [LW-1:0]        r_top, n_top;
    t_status              r_status, n_status;

    // Store bookkeeping.
    logic [LW-1:0]        r_free, n_free;
    logic [LW-1:0]        r_hwm, n_hwm;
    logic                 r_top_vld [K_STACKS];

    // Response register.
    logic                 r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]   r_out_value, n_out_value;
    t_status              r_out_status, n_out_status;

    // Stack select decoded from the incoming request.
    logic [KW-1:0]        in_sel;
    logic                 in_bad;

    // RAM ports.
    logic                 top_rd_en, top_wr_en;
    logic [KW-1:0]        top_rd_addr;
    logic [LW-1:0]        top_rd_data, top_wr_data;
    logic                 slot_rd_en, slot_wr_en;
    logic [AW-1:0]        slot_rd_addr;
    logic [SW-1:0]        slot_rd_data, slot_wr_data;

    logic [LW-1:0]        top_cur;
    logic [LW-1:0]        slot_pick;
    logic [LW-1:0]        next_free;
    logic                 commit;

    // Index K_STACKS folds onto the last stack; anything above is invalid.
    always_comb begin
        in_bad = 1'b0;
        in_sel = '0;
        if (int'(i_req.stack_index) < K_STACKS) begin
            in_sel = KW'(i_req.stack_index);
        end else if (int'(i_req.stack_index) == K_STACKS) begin
            in_sel = KW'(K_STACKS - 1);
        end else begin
            in_bad = 1'b1;
        end
    end

    kss_ram #(
        .WIDTH (LW),
        .DEPTH (K_STACKS)
    ) u_top_ram (
        .i_clk     (i_clk),
        .i_wr_en   (top_wr_en),
        .i_wr_addr (r_sel),
        .i_wr_data (top_wr_data),
        .i_rd_en   (top_rd_en),
        .i_rd_addr (top_rd_addr),
        .o_rd_data (top_rd_data)
    );

    // Each slot word carries the stored value above its link.
    kss_ram #(
        .WIDTH (SW),
        .DEPTH (N_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (r_slot[AW-1:0]),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_data)
    );

    // A stack never written since reset is empty.
    assign top_cur = r_top_vld[r_sel] ? top_rd_data : NULL_LINK;

    // Slots at or above the high-water mark still hold their reset link.
    assign next_free = (r_slot >= r_hwm) ? (r_slot + LW'(1)) : slot_rd_data[LW-1:0];

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_sel        = r_sel;
        n_bad        = r_bad;
        n_value      = r_value;
        n_slot       = r_slot;
        n_top        = r_top;
        n_status     = r_status;
        n_free       = r_free;
        n_hwm        = r_hwm;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        i_req.ready  = 1'b0;
        top_rd_en    = 1'b0;
        top_rd_addr  = in_sel;
        top_wr_en    = 1'b0;
        top_wr_data  = r_slot;
        slot_rd_en   = 1'b0;
        slot_pick    = r_free;
        slot_rd_addr = r_free[AW-1:0];
        slot_wr_en   = 1'b0;
        slot_wr_data = {r_value, r_top};
        commit       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    top_rd_en = 1'b1;
                    n_op      = t_op'(i_req.operation);
                    n_sel     = in_sel;
                    n_bad     = in_bad;
                    n_value   = i_req.push_value;
                    n_state   = S_TOP;
                end
            end
            S_TOP: begin
                // The index check comes before the full and empty checks.
                if (r_bad) begin
                    n_status = ST_BAD_INDEX;
                end else if (r_op == OP_PUSH && r_free == NULL_LINK) begin
                    n_status = ST_OVERFLOW;
                end else if (r_op == OP_POP && top_cur == NULL_LINK) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_status = ST_OK;
                end
                slot_pick    = (r_op == OP_POP) ? top_cur : r_free;
                slot_rd_addr = slot_pick[AW-1:0];
                slot_rd_en   = (n_status == ST_OK);
                n_slot       = slot_pick;
                n_top        = top_cur;
                n_state      = S_MOD;
            end
            S_MOD: begin
                if (!r_out_valid || o_rsp.ready) begin
                    commit       = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = '1;
                    if (r_status == ST_OK) begin
                        top_wr_en  = 1'b1;
                        slot_wr_en = 1'b1;
                        if (r_op == OP_PUSH) begin
                            // New slot points at the old top and becomes the top.
                            top_wr_data  = r_slot;
                            slot_wr_data = {r_value, r_top};
                            n_free       = next_free;
                            if (r_slot == r_hwm) begin
                                n_hwm = r_hwm + LW'(1);
                            end
                        end else begin
                            // Old top goes back to the head of the free list.
                            n_out_value  = slot_rd_data[SW-1:LW];
                            top_wr_data  = slot_rd_data[LW-1:0];
                            slot_wr_data = {slot_rd_data[SW-1:LW], r_free};
                            n_free       = r_slot;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '0;
            r_hwm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_hwm       <= n_hwm;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < K_STACKS; k++) begin
                r_top_vld[k] <= 1'b0;
            end
        end else if (top_wr_en) begin
            r_top_vld[r_sel] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_sel        <= n_sel;
        r_bad        <= n_bad;
        r_value      <= n_value;
        r_slot       <= n_slot;
        r_top        <= n_top;
        r_status     <= n_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.pop_value = r_out_value;
    assign o_rsp.status    = r_out_status;

`ifndef SYNTH
    // The free-list head is a slot number or null, never beyond.
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= NULL_LINK)
        else $error("free-list head out of range");

    // The high-water mark never passes the slot count.
    a_hwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hwm <= NULL_LINK)
        else $error("high-water mark out of range");

    // An accepted request passes through S_TOP and then reaches the commit state S_MOD.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_TOP) ##1 (r_state == S_MOD))
        else $error("request sequencing broken");

    // A successful push moves the free-list head off the slot it used.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_op == OP_PUSH && r_status == ST_OK) |=> (r_free != $past(r_slot)))
        else $error("free-list head not advanced by push");

    // Pushes and failed requests always report -1.
    a_neg_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && (r_op == OP_PUSH || r_status != ST_OK)) |=> (r_out_value == '1))
        else $error("response value not -1");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the k-stack shared slot store: directed table, random phases.
`timescale 1ns / 1ps
module testbench;
    import kss_pkg::*;

    localparam int N_SLOTS      = N_SLOTS_DEF;
    localparam int K_STACKS     = K_STACKS_DEF;
    localparam int LINK_W       = $clog2(N_SLOTS + 1);
    localparam int N_DIRECTED   = 25;
    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 400;
    localparam int DRAIN_CYCLES = 20;

    // Null pointer is one code above the last slot number.
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(N_SLOTS);

    typedef struct packed {
        logic signed [VALUE_W-1:0] pop_value;
        t_status                   status;
    } t_stack_result;

    typedef struct {
        t_op                       op;
        logic [INDEX_W-1:0]        idx;
        logic signed [VALUE_W-1:0] val;
        bit                        result_given;
        t_stack_result             given;
    } t_stim_row;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } t_traffic_phase;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_BURSTY
    } t_rx_mode;

    logic clk;
    logic rst_n;

    kss_req_if req_bus ();
    kss_rsp_if rsp_bus ();

    k_stacks_shared_store_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the slot store, the free list and the stack tops.
    logic signed [VALUE_W-1:0] slot_value_mem [N_SLOTS];
    logic [LINK_W-1:0]         slot_link_mem  [N_SLOTS];
    logic [LINK_W-1:0]         stack_top_ptr  [K_STACKS];
    logic [LINK_W-1:0]         free_list_head;

    // Responses still owed by the block, oldest first.
    t_stack_result pending_results [$];

    int error_count = 0;
    int idle_cycles = 0;
    int burst_left  = 0;

    // Directed requests. Rows with a given result can be read off at a glance:
    // reset state, extremes and error codes. The others are checked against
    // the shadow model.
    t_stim_row directed_rows [N_DIRECTED] = '{
        // Empty stacks right after reset, through a direct index and index K.
        '{OP_POP,  4'd0,  32'sh0,        1'b1, '{-32'sd1, ST_UNDERFLOW}},
        '{OP_POP,  4'd8,  32'sh0,        1'b1, '{-32'sd1, ST_UNDERFLOW}},
        // A bad index wins over an empty stack.
        '{OP_POP,  4'd15, 32'sh0,        1'b1, '{-32'sd1, ST_BAD_INDEX}},
        '{OP_PUSH, 4'd9,  32'sh12345678, 1'b1, '{-32'sd1, ST_BAD_INDEX}},
        '{OP_PUSH, 4'd0,  32'sh7FFFFFFF, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_PUSH, 4'd7,  32'sh80000000, 1'b1, '{-32'sd1, ST_OK}},
        // Index K lands on the last stack, on top of the previous push.
        '{OP_PUSH, 4'd8,  32'sh00000000, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_PUSH, 4'd1,  32'shFFFFFFFF, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_PUSH, 4'd2,  32'shAAAAAAAA, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_PUSH, 4'd3,  32'sh55555555, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd7,  32'shFFFFFFFF, 1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd7,  32'sh0,        1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd8,  32'sh0,        1'b1, '{-32'sd1, ST_UNDERFLOW}},
        '{OP_POP,  4'd0,  32'shABCDEF01, 1'b0, '{-32'sd1, ST_OK}},
        '{OP_PUSH, 4'd4,  32'sh0F0F0F0F, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_PUSH, 4'd5,  32'shF0F0F0F0, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_PUSH, 4'd6,  32'sh00000001, 1'b1, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd1,  32'sh0,        1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd2,  32'sh0,        1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd3,  32'sh0,        1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd4,  32'sh0,        1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd5,  32'sh0,        1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd6,  32'sh0,        1'b0, '{-32'sd1, ST_OK}},
        '{OP_POP,  4'd14, 32'sh0,        1'b1, '{-32'sd1, ST_BAD_INDEX}},
        '{OP_PUSH, 4'd10, 32'sh7FFFFFFF, 1'b1, '{-32'sd1, ST_BAD_INDEX}}
    };

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_store_model();
        for (int i = 0; i < N_SLOTS; i++) begin
            slot_value_mem[i] = '0;
            slot_link_mem[i]  = LINK_W'(i + 1);
        end
        for (int s = 0; s < K_STACKS; s++) begin
            stack_top_ptr[s] = NULL_LINK;
        end
        free_list_head = '0;
    endtask

    // Applies one request to the shadow store and returns the response it owes.
    // The index is checked before anything else; a failing request leaves the
    // store untouched.
    function automatic t_stack_result apply_stack_op(
        input t_op                       op,
        input logic [INDEX_W-1:0]        idx,
        input logic signed [VALUE_W-1:0] val
    );
        t_stack_result     res;
        logic [LINK_W-1:0] slot;
        int                sel;
        res.pop_value = -32'sd1;
        res.status    = ST_OK;
        if (idx > K_STACKS) begin
            res.status = ST_BAD_INDEX;
        end else begin
            sel = (idx == K_STACKS) ? K_STACKS - 1 : int'(idx);
            if (op == OP_PUSH) begin
                slot = free_list_head;
                if (slot == NULL_LINK) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    free_list_head      = slot_link_mem[slot];
                    slot_value_mem[slot] = val;
                    slot_link_mem[slot]  = stack_top_ptr[sel];
                    stack_top_ptr[sel]   = slot;
                end
            end else begin
                slot = stack_top_ptr[sel];
                if (slot == NULL_LINK) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.pop_value       = slot_value_mem[slot];
                    stack_top_ptr[sel]  = slot_link_mem[slot];
                    slot_link_mem[slot] = free_list_head;
                    free_list_head      = slot;
                end
            end
        end
        return res;
    endfunction

    // Drives one request and waits for the block to take it. The sender works
    // in bursts: when a burst runs out, valid may drop for a random gap before the
    // next one starts. Inside a burst valid stays high from request to request.
    task automatic issue_request(
        input t_op                       op,
        input logic [INDEX_W-1:0]        idx,
        input logic signed [VALUE_W-1:0] val,
        input bit                        result_given,
        input t_stack_result             given
    );
        int            gap;
        t_stack_result predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                req_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        req_bus.valid       <= 1'b1;
        req_bus.operation   <= op;
        req_bus.stack_index <= idx;
        req_bus.push_value  <= val;
        burst_left--;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        // The shadow model always advances, even when the row supplies the result.
        predicted = apply_stack_op(op, idx, val);
        pending_results.push_back(result_given ? given : predicted);
    endtask

    // Mostly plain random data, with the signed extremes mixed in now and then.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh80000000;
            1:       return 32'sh7FFFFFFF;
            2:       return 32'sh00000000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: the ready pattern switches between always ready, coin-flip
    // ready and runs of stall cycles, so back-pressure stalls requests at the commit
    // state and, through it, holds off the request channel.
    initial begin : response_sink
        t_rx_mode rx_mode;
        int       mode_left;
        int       stall_left;
        rsp_bus.ready = 1'b0;
        rx_mode       = RX_FREE;
        mode_left     = 0;
        stall_left    = 0;
        forever begin
            @(negedge clk);
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE: begin
                    rsp_bus.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                end
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rsp_bus.ready <= 1'b0;
                    end else if ($urandom_range(0, 3) == 0) begin
                        stall_left = $urandom_range(0, 9);
                        rsp_bus.ready <= 1'b0;
                    end else begin
                        rsp_bus.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Every accepted response is matched against the oldest outstanding one.
    always @(posedge clk) begin : response_check
        t_stack_result oldest;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding: pop_value %0d status %0d",
                       rsp_bus.pop_value, rsp_bus.status);
                error_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (rsp_bus.pop_value !== oldest.pop_value) begin
                    $error("pop_value mismatch: expected %0d, actual %0d",
                           oldest.pop_value, rsp_bus.pop_value);
                    error_count++;
                end
                if (rsp_bus.status !== oldest.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           oldest.status, rsp_bus.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves anything.
    always @(posedge clk) begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_traffic_phase     phase;
        int                 phase_len;
        int                 push_pct;
        int                 random_count;
        t_op                op;
        logic [INDEX_W-1:0] idx;
        bit                 first_phase;

        req_bus.valid       = 1'b0;
        req_bus.operation   = OP_PUSH;
        req_bus.stack_index = '0;
        req_bus.push_value  = '0;
        rst_n               = 1'b0;
        clear_store_model();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            issue_request(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].val,
                          directed_rows[r].result_given, directed_rows[r].given);
        end

        // Random traffic in phases. A push-heavy phase fills the store until
        // pushes overflow, a pop-heavy one drains stacks until pops underflow,
        // and mixed phases churn the free list in between. The first phase is
        // always a fill so that the full store is reached early.
        random_count = 0;
        first_phase  = 1'b1;
        while (random_count < RANDOM_ITEMS) begin
            if (first_phase) begin
                phase     = PH_FILL;
                phase_len = 100;
            end else begin
                phase     = t_traffic_phase'($urandom_range(0, 2));
                phase_len = $urandom_range(20, 150);
            end
            first_phase = 1'b0;
            case (phase)
                PH_FILL:  push_pct = 90;
                PH_DRAIN: push_pct = 15;
                default:  push_pct = 50;
            endcase
            for (int n = 0; n < phase_len && random_count < RANDOM_ITEMS; n++) begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                // Index K and the invalid range above it both appear regularly.
                if ($urandom_range(0, 9) == 0) begin
                    idx = INDEX_W'($urandom_range(K_STACKS + 1, 15));
                end else begin
                    idx = INDEX_W'($urandom_range(0, K_STACKS));
                end
                issue_request(op, idx, pick_value(), 1'b0, '{-32'sd1, ST_OK});
                random_count++;
            end
        end

        @(negedge clk);
        req_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
